// ===== hw/rtl/cpg_pkg.sv =====
`default_nettype none

package cpg_pkg;

    // Number of CORDIC rotations, one pipeline stage each.
    localparam int ROTATION_STEPS = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int ATAN_IDX_W     = $clog2(ATAN_ENTRIES);

    // Field widths.
    localparam int TIME_W   = 24;
    localparam int RADIUS_W = 16;
    localparam int RATE_W   = 20;
    localparam int ANGLE_W  = 16;
    localparam int OUT_W    = 17;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    // Datapath widths: x/y carry radius * 2^14, z is a 2^32-per-turn angle.
    localparam int XY_W    = 32;
    localparam int Z_W     = 32;
    localparam int GAIN_W  = 30;
    localparam int GPROD_W = RADIUS_W + GAIN_W;

    // Gain compensation, unsigned Q30.
    localparam longint GAIN_LIMIT_Q30 = 64'd652032874;
    localparam longint GAIN_TAIL_Q30  = 64'd434688582;
    localparam logic [GAIN_W-1:0] GAIN_Q30 =
        GAIN_W'(GAIN_LIMIT_Q30 + (GAIN_TAIL_Q30 >> (2 * ROTATION_STEPS)));

    // Output rounding and clamp.
    localparam int RND_SHIFT = 14;
    localparam logic signed [OUT_W+1:0] OUT_LIMIT = 19'sd65535;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE  = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [RATE_W-1:0]   RATE_RST   = 20'd10430;
    localparam logic [ANGLE_W-1:0]  START_RST  = 16'd0;

    // atan(2^-i) in units of 2^32 per turn.
    localparam logic [Z_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
    } cordic_vec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/circular_position_generator.sv =====
// Circular position generator: for each time beat t on the s_ channel it sends
// one beat on the m_ channel with pos_x = R*cos(w*t + phase) and
// pos_y = R*sin(w*t + phase), signed Q8.8, rounded to nearest and clamped.
// R, w and phase are written through cfg_we/cfg_addr/cfg_wdata (0: radius,
// 1: angular_rate, 2: start_angle); write them only while no beat is in flight.
// Throughput: one beat per clock while m_tready is high. The pipeline has 19
// register stages between input and m_tvalid - two stages for the multiplies
// and the angle wrap, one per CORDIC rotation (16), and one for quadrant
// fix-up and rounding.
// Every stage has its own valid bit and a ready that looks only at the next
// stage, so bubbles collapse and new beats are taken while a result waits.
// When m_tready is low the pipeline fills up and then drops s_tready; nothing
// is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads
// radius = 1.0, angular_rate = 10430, start_angle = 0.
`default_nettype none

module circular_position_generator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [cpg_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [cpg_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,   // [23:0] time_value
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [39:0]                         m_tdata    // [16:0] pos_x, [33:17] pos_y
);

    logic [cpg_pkg::RADIUS_W-1:0]   radius_reg;
    logic [cpg_pkg::RATE_W-1:0]     angular_rate_reg;
    logic [cpg_pkg::ANGLE_W-1:0]    start_angle_reg;

    logic                           ang_valid;
    logic                           ang_ready;
    cpg_pkg::cordic_vec_t           ang_vec;
    logic                           rot_valid;
    logic                           rot_ready;
    cpg_pkg::cordic_vec_t           rot_vec;
    logic [cpg_pkg::OUT_W-1:0]      pos_x;
    logic [cpg_pkg::OUT_W-1:0]      pos_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg       <= cpg_pkg::RADIUS_RST;
            angular_rate_reg <= cpg_pkg::RATE_RST;
            start_angle_reg  <= cpg_pkg::START_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                cpg_pkg::REG_RADIUS:
                    radius_reg <= cfg_wdata[cpg_pkg::RADIUS_W-1:0];
                cpg_pkg::REG_ANGULAR_RATE:
                    angular_rate_reg <= cfg_wdata[cpg_pkg::RATE_W-1:0];
                cpg_pkg::REG_START_ANGLE:
                    start_angle_reg <= cfg_wdata[cpg_pkg::ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cpg_angle u_angle (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .time_value   (s_tdata[cpg_pkg::TIME_W-1:0]),
        .radius       (radius_reg),
        .angular_rate (angular_rate_reg),
        .start_angle  (start_angle_reg),
        .out_valid    (ang_valid),
        .out_ready    (ang_ready),
        .out_vec      (ang_vec)
    );

    cpg_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ang_valid),
        .in_ready  (ang_ready),
        .in_vec    (ang_vec),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_vec   (rot_vec)
    );

    cpg_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_vec    (rot_vec),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

    assign m_tdata = {6'b000000, pos_y, pos_x};

endmodule

`default_nettype wire

// ===== hw/rtl/cpg_angle.sv =====
`default_nettype none

module cpg_angle (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [cpg_pkg::TIME_W-1:0]         time_value,
    input  wire logic [cpg_pkg::RADIUS_W-1:0]       radius,
    input  wire logic [cpg_pkg::RATE_W-1:0]         angular_rate,
    input  wire logic [cpg_pkg::ANGLE_W-1:0]        start_angle,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output cpg_pkg::cordic_vec_t                    out_vec
);

    // Stage A: both products.
    logic                               a_valid_reg;
    logic [cpg_pkg::TIME_W-1:0]         phase_prod_reg;
    logic [cpg_pkg::GPROD_W-1:0]        gain_prod_reg;
    logic [cpg_pkg::TIME_W-1:0]         rate_ext;
    logic [cpg_pkg::TIME_W-1:0]         phase_prod_next;
    logic [cpg_pkg::GPROD_W-1:0]        gain_prod_next;
    logic                               a_ready;

    // Stage B: wrapped angle and start vector.
    logic                               b_valid_reg;
    cpg_pkg::cordic_vec_t               b_vec_reg;
    cpg_pkg::cordic_vec_t               b_vec_next;
    logic [cpg_pkg::ANGLE_W-1:0]        angle;
    logic                               b_ready;

    assign rate_ext = {{(cpg_pkg::TIME_W - cpg_pkg::RATE_W){angular_rate[cpg_pkg::RATE_W-1]}},
                       angular_rate};
    // Only the low 24 product bits reach the wrapped angle.
    assign phase_prod_next = rate_ext * time_value;
    assign gain_prod_next  = cpg_pkg::GPROD_W'(radius) * cpg_pkg::GPROD_W'(cpg_pkg::GAIN_Q30);

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
        if (a_ready && in_valid) begin
            phase_prod_reg <= phase_prod_next;
            gain_prod_reg  <= gain_prod_next;
        end
    end

    always_comb begin
        angle           = phase_prod_reg[23:8] + start_angle;
        b_vec_next.x    = cpg_pkg::XY_W'(gain_prod_reg[cpg_pkg::GPROD_W-1:16]);
        b_vec_next.y    = '0;
        b_vec_next.z    = {2'b00, angle[13:0], 16'h0000};
        b_vec_next.quad = angle[15:14];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_ready && a_valid_reg) begin
            b_vec_reg <= b_vec_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_vec   = b_vec_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cpg_cordic.sv =====
`default_nettype none

module cpg_cordic (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire cpg_pkg::cordic_vec_t   in_vec,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output cpg_pkg::cordic_vec_t        out_vec
);

    localparam int STEPS = cpg_pkg::ROTATION_STEPS;

    logic                   vld_reg  [STEPS];
    cpg_pkg::cordic_vec_t   vec_reg  [STEPS];
    cpg_pkg::cordic_vec_t   vec_next [STEPS];
    logic                   src_valid [STEPS];
    cpg_pkg::cordic_vec_t   src_vec  [STEPS];
    logic                   rdy      [STEPS+1];

    assign rdy[STEPS] = out_ready;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        if (i == 0) begin : g_first
            assign src_valid[i] = in_valid;
            assign src_vec[i]   = in_vec;
        end else begin : g_next
            assign src_valid[i] = vld_reg[i-1];
            assign src_vec[i]   = vec_reg[i-1];
        end

        assign rdy[i] = !vld_reg[i] || rdy[i+1];

        always_comb begin
            vec_next[i].quad = src_vec[i].quad;
            // z >= 0 rotates forward; shifts floor toward minus infinity
            if (!src_vec[i].z[cpg_pkg::Z_W-1]) begin
                vec_next[i].x = src_vec[i].x - (src_vec[i].y >>> i);
                vec_next[i].y = src_vec[i].y + (src_vec[i].x >>> i);
                vec_next[i].z = src_vec[i].z
                              - $signed(cpg_pkg::ATAN_TURNS[cpg_pkg::ATAN_IDX_W'(i)]);
            end else begin
                vec_next[i].x = src_vec[i].x + (src_vec[i].y >>> i);
                vec_next[i].y = src_vec[i].y - (src_vec[i].x >>> i);
                vec_next[i].z = src_vec[i].z
                              + $signed(cpg_pkg::ATAN_TURNS[cpg_pkg::ATAN_IDX_W'(i)]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                vld_reg[i] <= src_valid[i];
            end
            if (rdy[i] && src_valid[i]) begin
                vec_reg[i] <= vec_next[i];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STEPS-1];
    assign out_vec   = vec_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/cpg_output.sv =====
`default_nettype none

module cpg_output (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire cpg_pkg::cordic_vec_t       in_vec,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [cpg_pkg::OUT_W-1:0]       pos_x,
    output logic [cpg_pkg::OUT_W-1:0]       pos_y
);

    logic                                   vld_reg;
    logic [cpg_pkg::OUT_W-1:0]              pos_x_reg;
    logic [cpg_pkg::OUT_W-1:0]              pos_y_reg;
    logic [cpg_pkg::OUT_W-1:0]              pos_x_next;
    logic [cpg_pkg::OUT_W-1:0]              pos_y_next;
    logic signed [cpg_pkg::XY_W-1:0]        ox;
    logic signed [cpg_pkg::XY_W-1:0]        oy;

    function automatic logic [cpg_pkg::OUT_W-1:0] round_sat(
        input logic signed [cpg_pkg::XY_W-1:0] v
    );
        logic signed [cpg_pkg::XY_W:0]    w;
        logic signed [cpg_pkg::OUT_W+1:0] r;
        logic [cpg_pkg::OUT_W-1:0]        res;
        w = (cpg_pkg::XY_W+1)'(v) + (cpg_pkg::XY_W+1)'(1 << (cpg_pkg::RND_SHIFT - 1));
        r = (cpg_pkg::OUT_W+2)'(w >>> cpg_pkg::RND_SHIFT);
        if (r > cpg_pkg::OUT_LIMIT) begin
            res = cpg_pkg::OUT_W'(cpg_pkg::OUT_LIMIT);
        end else if (r < -cpg_pkg::OUT_LIMIT) begin
            res = cpg_pkg::OUT_W'(-cpg_pkg::OUT_LIMIT);
        end else begin
            res = r[cpg_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    // Quadrant fix-up.
    always_comb begin
        unique case (in_vec.quad)
            2'd0: begin
                ox = in_vec.x;
                oy = in_vec.y;
            end
            2'd1: begin
                ox = -in_vec.y;
                oy = in_vec.x;
            end
            2'd2: begin
                ox = -in_vec.x;
                oy = -in_vec.y;
            end
            default: begin
                ox = in_vec.y;
                oy = -in_vec.x;
            end
        endcase
    end

    assign pos_x_next = round_sat(ox);
    assign pos_y_next = round_sat(oy);
    assign in_ready   = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign out_valid = vld_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

endmodule

`default_nettype wire
